// File: rtl/core/sorted_priority_queue_defines.svh
// assertion macros for the sorted priority queue
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SPQ_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("spq assertion failed");

// next-cycle implication, disabled while in reset
`define SPQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("spq assertion failed");

`endif

// File: rtl/core/spq_pkg.sv
// types and constants shared by the sorted priority queue
package spq_pkg;

  localparam int unsigned DEPTH_DEF     = 512;
  localparam int unsigned KEY_WIDTH_DEF = 32;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned HANDLE_W = 9;
  localparam int unsigned COUNT_W  = 10;

  typedef enum logic {
    CMD_ENQ,
    CMD_DEQ
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE,
    ST_EMPTY,
    ST_FULL
  } status_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] item_handle;
  } in_t;

  typedef struct packed {
    status_e             status;
    logic [KEY_W-1:0]    out_key;
    logic [HANDLE_W-1:0] out_handle;
    logic [COUNT_W-1:0]  entry_count;
  } out_t;

  // broadcast from the control to every cell
  typedef struct packed {
    logic                enq;
    logic                deq;
    logic [HANDLE_W-1:0] handle;
  } cell_ctl_t;

endpackage

// File: rtl/core/sorted_priority_queue.sv
// a result appears in the cycle after its transaction is accepted
// throughput: one transaction per cycle unless stalled; cells shift or load in parallel
// the output register holds a result while out_stall_i is high, and input stalls only then
// reset clears the entry count and the output valid; cell contents stay undefined
// until written, and no clearing pass is needed
module sorted_priority_queue #(
  parameter int unsigned DEPTH     = spq_pkg::DEPTH_DEF,
  parameter int unsigned KEY_WIDTH = spq_pkg::KEY_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  spq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output spq_pkg::out_t out_data_o
);

  `include "sorted_priority_queue_defines.svh"

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0]         count_q, count_d;
  logic                  out_valid_q;
  spq_pkg::out_t         out_data_q, out_data_d;

  logic                  accept, is_enq, full, empty, do_enq, do_deq;
  logic [KEY_WIDTH-1:0]  new_key;
  spq_pkg::cell_ctl_t    ctl;

  logic                         ge_w     [DEPTH];
  logic [KEY_WIDTH-1:0]         key_w    [DEPTH];
  logic [spq_pkg::HANDLE_W-1:0] handle_w [DEPTH];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_enq     = (in_data_i.cmd == spq_pkg::CMD_ENQ);
  assign full       = (count_q == CW'(DEPTH));
  assign empty      = (count_q == '0);
  assign do_enq     = accept && is_enq && !full;
  assign do_deq     = accept && !is_enq && !empty;
  assign new_key    = KEY_WIDTH'(in_data_i.key);

  assign ctl.enq    = do_enq;
  assign ctl.deq    = do_deq;
  assign ctl.handle = in_data_i.item_handle;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                         occ;
    logic                         prev_ge;
    logic [KEY_WIDTH-1:0]         prev_key, next_key;
    logic [spq_pkg::HANDLE_W-1:0] prev_handle, next_handle;

    assign occ = (count_q > CW'(i));

    if (i == 0) begin : g_head
      assign prev_ge     = 1'b0;
      assign prev_key    = '0;
      assign prev_handle = '0;
    end else begin : g_body
      assign prev_ge     = ge_w[i-1];
      assign prev_key    = key_w[i-1];
      assign prev_handle = handle_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_key    = key_w[i];
      assign next_handle = handle_w[i];
    end else begin : g_link
      assign next_key    = key_w[i+1];
      assign next_handle = handle_w[i+1];
    end

    spq_cell #(
      .KEY_WIDTH (KEY_WIDTH)
    ) u_cell (
      .clk_i         (clk_i),
      .ctl_i         (ctl),
      .new_key_i     (new_key),
      .occ_i         (occ),
      .prev_ge_i     (prev_ge),
      .prev_key_i    (prev_key),
      .prev_handle_i (prev_handle),
      .next_key_i    (next_key),
      .next_handle_i (next_handle),
      .ge_o          (ge_w[i]),
      .key_o         (key_w[i]),
      .handle_o      (handle_w[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (do_enq) begin
      count_d = count_q + CW'(1);
    end else if (do_deq) begin
      count_d = count_q - CW'(1);
    end
  end

  always_comb begin
    out_data_d.status      = spq_pkg::ST_DONE;
    out_data_d.out_key     = '0;
    out_data_d.out_handle  = '0;
    out_data_d.entry_count = spq_pkg::COUNT_W'(count_d);
    if (is_enq && full) begin
      out_data_d.status = spq_pkg::ST_FULL;
    end else if (!is_enq && empty) begin
      out_data_d.status = spq_pkg::ST_EMPTY;
    end else if (!is_enq) begin
      out_data_d.out_key    = spq_pkg::KEY_W'(key_w[0]);
      out_data_d.out_handle = handle_w[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `SPQ_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CW'(DEPTH))
  `SPQ_ASSERT_NEXT(a_enq_count, clk_i, rst_ni, do_enq, count_q == $past(count_q) + CW'(1))
  `SPQ_ASSERT_NEXT(a_deq_head, clk_i, rst_ni, do_deq, out_data_o.out_handle == $past(handle_w[0]))
  `SPQ_ASSERT_NOW(a_head_sorted, clk_i, rst_ni, count_q >= CW'(2), key_w[0] <= key_w[1])

endmodule

// File: rtl/core/spq_cell.sv
// one storage cell of the shift-register priority queue
module spq_cell #(
  parameter int unsigned KEY_WIDTH = spq_pkg::KEY_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  spq_pkg::cell_ctl_t            ctl_i,
  input  logic [KEY_WIDTH-1:0]          new_key_i,
  input  logic                          occ_i,
  input  logic                          prev_ge_i,
  input  logic [KEY_WIDTH-1:0]          prev_key_i,
  input  logic [spq_pkg::HANDLE_W-1:0]  prev_handle_i,
  input  logic [KEY_WIDTH-1:0]          next_key_i,
  input  logic [spq_pkg::HANDLE_W-1:0]  next_handle_i,
  output logic                          ge_o,
  output logic [KEY_WIDTH-1:0]          key_o,
  output logic [spq_pkg::HANDLE_W-1:0]  handle_o
);

  logic [KEY_WIDTH-1:0]         key_q, key_d;
  logic [spq_pkg::HANDLE_W-1:0] handle_q, handle_d;

  // empty cells count as not smaller, so an entry above every stored key lands at the tail
  assign ge_o = !occ_i || (key_q >= new_key_i);

  always_comb begin
    key_d    = key_q;
    handle_d = handle_q;
    if (ctl_i.enq && ge_o) begin
      if (prev_ge_i) begin
        key_d    = prev_key_i;
        handle_d = prev_handle_i;
      end else begin
        key_d    = new_key_i;
        handle_d = ctl_i.handle;
      end
    end else if (ctl_i.deq) begin
      key_d    = next_key_i;
      handle_d = next_handle_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    handle_q <= handle_d;
  end

  assign key_o    = key_q;
  assign handle_o = handle_q;

endmodule

// File: tb/sv/sorted_priority_queue_test.sv
// self-checking testbench for the sorted priority queue, with a predictor and random idling
`timescale 1ns / 100ps

module sorted_priority_queue_test;

  localparam int DEPTH      = spq_pkg::DEPTH_DEF;
  localparam int IDLE_PCT   = 29;
  localparam int WATCHDOG   = 2000;

  logic          clk_i;
  logic          rst_ni = 1'b0;
  logic          in_valid = 1'b0;
  spq_pkg::in_t  in_data = '0;
  logic          out_stall = 1'b0;
  logic          in_stall_o;
  logic          out_valid_o;
  spq_pkg::out_t out_data_o;

  spq_pkg::in_t  pending_items[$];
  spq_pkg::out_t expected_results[$];

  // predicted queue contents
  logic [spq_pkg::KEY_W-1:0]    held_keys[DEPTH];
  logic [spq_pkg::HANDLE_W-1:0] held_handles[DEPTH];
  int                           held_entries = 0;

  int planned_count   = 0;
  int accepted_inputs = 0;
  int error_count     = 0;
  int quiet_cycles    = 0;
  spq_pkg::out_t want;

  sorted_priority_queue #(
    .DEPTH    (DEPTH),
    .KEY_WIDTH(spq_pkg::KEY_WIDTH_DEF)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic spq_pkg::out_t apply_queue_op(spq_pkg::in_t op);
    spq_pkg::out_t res;
    int slot;
    res = '0;
    res.status = spq_pkg::ST_DONE;
    if (op.cmd == spq_pkg::CMD_ENQ) begin
      if (held_entries >= DEPTH) begin
        res.status = spq_pkg::ST_FULL;
      end else begin
        slot = 0;
        while (slot < held_entries && held_keys[slot] < op.key) slot++;
        for (int i = held_entries; i > slot; i--) begin
          held_keys[i]    = held_keys[i-1];
          held_handles[i] = held_handles[i-1];
        end
        held_keys[slot]    = op.key;
        held_handles[slot] = op.item_handle;
        held_entries++;
      end
    end else begin
      if (held_entries == 0) begin
        res.status = spq_pkg::ST_EMPTY;
      end else begin
        res.out_key    = held_keys[0];
        res.out_handle = held_handles[0];
        for (int i = 1; i < held_entries; i++) begin
          held_keys[i-1]    = held_keys[i];
          held_handles[i-1] = held_handles[i];
        end
        held_entries--;
      end
    end
    res.entry_count = spq_pkg::COUNT_W'(held_entries);
    return res;
  endfunction

  // no idling while the calm window is open
  function automatic logic take_break();
    if (accepted_inputs >= 700 && accepted_inputs < 1000) return 1'b0;
    return $urandom_range(99) < IDLE_PCT;
  endfunction

  function automatic logic [spq_pkg::KEY_W-1:0] pick_key();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [spq_pkg::HANDLE_W-1:0] pick_handle();
    return spq_pkg::HANDLE_W'($urandom_range(0, 511));
  endfunction

  task automatic queue_item(spq_pkg::cmd_e cmd, logic [spq_pkg::KEY_W-1:0] key,
                            logic [spq_pkg::HANDLE_W-1:0] handle);
    spq_pkg::in_t item;
    item.cmd         = cmd;
    item.key         = key;
    item.item_handle = handle;
    pending_items.push_back(item);
    if (cmd == spq_pkg::CMD_ENQ && planned_count < DEPTH) planned_count++;
    if (cmd == spq_pkg::CMD_DEQ && planned_count > 0) planned_count--;
  endtask

  task automatic random_mix(int count, int enq_pct);
    for (int n = 0; n < count; n++) begin
      queue_item($urandom_range(99) < enq_pct ? spq_pkg::CMD_ENQ : spq_pkg::CMD_DEQ,
                 pick_key(), pick_handle());
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  // driver and predictor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) begin
        expected_results.push_back(apply_queue_op(in_data));
        accepted_inputs++;
      end
      if (!in_valid || !in_stall_o) begin
        if (pending_items.size() != 0 && !take_break()) begin
          in_valid <= 1'b1;
          in_data  <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no transaction pending, actual %h", $time, out_data_o);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data_o.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     out_data_o.status);
            error_count++;
          end
          if (out_data_o.out_key !== want.out_key) begin
            $display("%0t: out_key expected %h actual %h", $time, want.out_key,
                     out_data_o.out_key);
            error_count++;
          end
          if (out_data_o.out_handle !== want.out_handle) begin
            $display("%0t: out_handle expected %h actual %h", $time, want.out_handle,
                     out_data_o.out_handle);
            error_count++;
          end
          if (out_data_o.entry_count !== want.entry_count) begin
            $display("%0t: entry_count expected %0d actual %0d", $time, want.entry_count,
                     out_data_o.entry_count);
            error_count++;
          end
        end
      end
      out_stall <= take_break();
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG) begin
        $display("%0t: timeout", $time);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    // empty queue, extremes, ties among equal keys
    queue_item(spq_pkg::CMD_DEQ, '1, '1);
    queue_item(spq_pkg::CMD_ENQ, '0, '0);
    queue_item(spq_pkg::CMD_ENQ, '1, 9'h1FF);
    queue_item(spq_pkg::CMD_ENQ, 32'd5, 9'd1);
    queue_item(spq_pkg::CMD_ENQ, 32'd5, 9'd2);
    queue_item(spq_pkg::CMD_ENQ, 32'd5, 9'd3);
    queue_item(spq_pkg::CMD_ENQ, 32'h8000_0000, 9'h155);
    queue_item(spq_pkg::CMD_ENQ, 32'h7FFF_FFFF, 9'h0AA);
    queue_item(spq_pkg::CMD_ENQ, '0, 9'd7);
    queue_item(spq_pkg::CMD_ENQ, 32'h5555_5555, 9'h100);
    repeat (10) queue_item(spq_pkg::CMD_DEQ, 32'hAAAA_AAAA, 9'h0FF);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_drained();

    random_mix(400, 55);
    while (planned_count < DEPTH) begin
      queue_item($urandom_range(99) < 85 ? spq_pkg::CMD_ENQ : spq_pkg::CMD_DEQ,
                 pick_key(), pick_handle());
    end
    repeat (3) queue_item(spq_pkg::CMD_ENQ, pick_key(), pick_handle());
    repeat (12) begin
      queue_item(spq_pkg::CMD_DEQ, pick_key(), pick_handle());
      queue_item(spq_pkg::CMD_ENQ, pick_key(), pick_handle());
      queue_item(spq_pkg::CMD_ENQ, pick_key(), pick_handle());
    end
    while (planned_count > 0) begin
      queue_item($urandom_range(99) < 85 ? spq_pkg::CMD_DEQ : spq_pkg::CMD_ENQ,
                 pick_key(), pick_handle());
    end
    repeat (3) queue_item(spq_pkg::CMD_DEQ, pick_key(), pick_handle());
    random_mix(300, 50);

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue.sv
tb/sv/sorted_priority_queue_test.sv
